// File: design/nbswp_pkg.sv
package nbswp_pkg;

  localparam int unsigned MAX_BURST_WORDS = 8192;
  localparam logic [8:0]  DC_BIT          = 9'h100;
  localparam logic [8:0]  BYTE_MASK       = 9'h0FF;
  localparam logic [7:0]  NOOP_WORD       = 8'h00;

  // one accepted input beat
  typedef struct packed {
    logic        word_dc;
    logic [7:0]  word_byte;
    logic        first_word;
    logic [13:0] burst_words;
    logic        last_word;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic [8:0] out_word;
    logic       out_last;
    logic       length_error;
  } out_item_t;

  // packer state carried between cycles
  typedef struct packed {
    logic [7:0] acc;    // held stream bits, low aligned
    logic [3:0] held;   // valid bits in acc, 0..8
    logic [2:0] grp;    // position in 8-word group
    logic [3:0] left;   // words of the current item not yet loaded
  } step_state_t;

endpackage

// File: design/nbswp_if.sv
interface nbswp_in_if;
  logic        valid;
  logic        ready;
  logic        word_dc;
  logic [7:0]  word_byte;
  logic        first_word;
  logic [13:0] burst_words;
  logic        last_word;

  modport source (output valid, word_dc, word_byte, first_word, burst_words, last_word,
                  input ready);
  modport sink   (input valid, word_dc, word_byte, first_word, burst_words, last_word,
                  output ready);
endinterface

interface nbswp_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] out_word;
  logic       out_last;
  logic       length_error;

  modport source (output valid, out_word, out_last, length_error, input ready);
  modport sink   (input valid, out_word, out_last, length_error, output ready);
endinterface

interface nbswp_cfg_if;
  logic valid;
  logic ready;
  logic emulate_eight_bit;

  modport source (output valid, emulate_eight_bit, input ready);
  modport sink   (input valid, emulate_eight_bit, output ready);
endinterface

// File: design/nine_bit_spi_word_packer.sv
// Nine-bit display-bus word packer. Each input beat is one bus word (DC bit
// plus byte); a first word may be preceded by up to seven zero no-op words so
// the burst length becomes a multiple of 8. With emulate_eight_bit set the
// 9-bit words are streamed MSB first into bytes (8 words -> 9 bytes), with a
// zero-filled flush byte and length_error on a short final group; cleared,
// each 9-bit word leaves as is. Results leave at one beat per clock while
// out_bus.ready is high, from a single output register; an input beat is
// held until its last result is registered (padding words plus one or two
// bytes per word plus a flush); the next input beat is taken in that same
// cycle, so single-result words go at one beat per clock when not stalled.
// Write emulate_eight_bit only while the block is idle; cfg ready is always 1.
module nine_bit_spi_word_packer
  import nbswp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  nbswp_in_if.sink          in_bus,
  nbswp_out_if.source       out_bus,
  nbswp_cfg_if.sink         cfg_bus
);

  in_item_t    item_r;
  logic        item_vld_r;
  logic        busy_r;      // current item has produced at least one result
  step_state_t st_r;
  logic        emu_r;
  out_item_t   out_r;
  logic        out_vld_r;

  out_item_t   out_nxt;
  step_state_t st_nxt;
  logic        done;
  logic        fire;
  logic        take;
  in_item_t    in_item;

  assign in_item = '{word_dc:     in_bus.word_dc,
                     word_byte:   in_bus.word_byte,
                     first_word:  in_bus.first_word,
                     burst_words: in_bus.burst_words,
                     last_word:   in_bus.last_word};

  nbswp_step u_step (
    .item   (item_r),
    .emu    (emu_r),
    .busy   (busy_r),
    .st     (st_r),
    .res    (out_nxt),
    .st_nxt (st_nxt),
    .done   (done)
  );

  // produce one result whenever an item is held and the output register is free or draining
  assign fire = item_vld_r && (!out_vld_r || out_bus.ready);
  assign take = fire && done;

  assign in_bus.ready  = !item_vld_r || take;
  assign cfg_bus.ready = 1'b1;

  assign out_bus.valid        = out_vld_r;
  assign out_bus.out_word     = out_r.out_word;
  assign out_bus.out_last     = out_r.out_last;
  assign out_bus.length_error = out_r.length_error;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      busy_r     <= 1'b0;
      st_r       <= '0;
      emu_r      <= 1'b1;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_bus.valid) begin
        emu_r <= cfg_bus.emulate_eight_bit;
      end
      if (in_bus.valid && in_bus.ready) begin
        item_vld_r <= 1'b1;
      end else if (take) begin
        item_vld_r <= 1'b0;
      end
      if (fire) begin
        st_r      <= st_nxt;
        busy_r    <= !done;
        out_vld_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      item_r <= in_item;
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

endmodule

// File: design/nbswp_step.sv
module nbswp_step
  import nbswp_pkg::*;
(
  input  in_item_t    item,
  input  logic        emu,
  input  logic        busy,
  input  step_state_t st,
  output out_item_t   res,
  output step_state_t st_nxt,
  output logic        done
);

  logic [2:0]  rem;
  logic [2:0]  pad;
  logic [3:0]  start_left;
  logic        fresh;
  logic [3:0]  left;
  logic [7:0]  acc;
  logic [3:0]  held;
  logic [2:0]  grp;
  logic [8:0]  word;
  logic [15:0] t;
  logic [4:0]  n;
  logic [7:0]  sh;
  logic [7:0]  flush;

  // padding words needed to round the burst count up to a multiple of 8
  assign rem = (item.burst_words > 14'(MAX_BURST_WORDS)) ? 3'(MAX_BURST_WORDS % 8)
                                                         : item.burst_words[2:0];
  assign pad = 3'(4'd8 - {1'b0, rem});
  assign start_left = item.first_word ? (4'({1'b0, pad}) + 4'd1) : 4'd1;

  // a first word starts from a clean state
  assign fresh = !busy && item.first_word;
  assign left  = busy ? st.left : start_left;
  assign acc   = fresh ? 8'd0 : st.acc;
  assign held  = fresh ? 4'd0 : st.held;
  assign grp   = fresh ? 3'd0 : st.grp;

  assign word  = (left == 4'd1)
               ? ((item.word_dc ? DC_BIT : 9'd0) | ({1'b0, item.word_byte} & BYTE_MASK))
               : {1'b0, NOOP_WORD};
  assign t     = {acc[6:0], word};
  assign n     = 5'(held) + 5'd9;
  assign sh    = 8'(t >> (n - 5'd8));
  assign flush = 8'(acc << (4'd8 - held));

  always_comb begin
    res          = '0;
    st_nxt       = st;
    st_nxt.acc   = acc;
    st_nxt.held  = held;
    st_nxt.grp   = grp;
    st_nxt.left  = left;
    done         = 1'b0;
    if (emu) begin
      if (held >= 4'd8) begin
        // a full byte is already held
        res.out_word = {1'b0, acc};
        st_nxt.held  = 4'd0;
        st_nxt.acc   = 8'd0;
      end else if (left != 4'd0) begin
        res.out_word = {1'b0, sh};
        st_nxt.held  = 4'(n - 5'd8);
        st_nxt.acc   = t[7:0] & 8'((9'd1 << st_nxt.held) - 9'd1);
        st_nxt.left  = left - 4'd1;
        st_nxt.grp   = grp + 3'd1;
      end else begin
        // tail bits of a last word, zero filled at the low end
        res.out_word = {1'b0, flush};
        st_nxt.held  = 4'd0;
        st_nxt.acc   = 8'd0;
      end
      done = (st_nxt.left == 4'd0) && (st_nxt.held < 4'd8) &&
             !(item.last_word && (st_nxt.held != 4'd0));
    end else begin
      res.out_word = word;
      st_nxt.acc   = 8'd0;
      st_nxt.held  = 4'd0;
      st_nxt.left  = left - 4'd1;
      st_nxt.grp   = grp + 3'd1;
      done         = (st_nxt.left == 4'd0);
    end
    if (done && item.last_word) begin
      res.out_last     = 1'b1;
      res.length_error = (st_nxt.grp != 3'd0);
      st_nxt.acc       = 8'd0;
      st_nxt.held      = 4'd0;
      st_nxt.grp       = 3'd0;
    end
  end

endmodule
